>>> rtl/pahr_pkg.sv
package pahr_pkg;

    // Default sizing
    localparam int PAHR_PAGE_COUNT = 65536;
    localparam int PAHR_NUM_BINS   = 30;

    // Fixed field widths at the ports
    localparam int OP_W        = 2;
    localparam int PAGE_IDX_W  = 16;
    localparam int TARGET_W    = 17;
    localparam int SCORE_OUT_W = 5;

    // Histogram bin width and its saturation point
    localparam int BIN_W   = 17;
    localparam int BIN_MAX = (1 << BIN_W) - 1;

    typedef enum logic [OP_W-1:0] {
        OP_OBSERVE = 2'd0,
        OP_CLOSE   = 2'd1,
        OP_VICTIM  = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_OBS_RD,
        S_OBS_UPD,
        S_OBS_HIST,
        S_SCAN_RD,
        S_SCAN_ACC,
        S_VIC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic clear_all;
    } t_hist_ctl;

endpackage

>>> rtl/pahr_page_mem.sv
module pahr_page_mem import pahr_pkg::*; #(
    parameter int PAGE_COUNT = PAHR_PAGE_COUNT,
    parameter int ADDR_W     = 16,
    parameter int DATA_W     = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    // Each word: swapped mark on top, score below
    logic [DATA_W-1:0] r_mem [PAGE_COUNT];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pahr_hist_mem.sv
module pahr_hist_mem import pahr_pkg::*; #(
    parameter int DEPTH  = PAHR_NUM_BINS,
    parameter int ADDR_W = 5,
    parameter int DATA_W = BIN_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_hist_ctl         i_ctl,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [DEPTH-1:0]  r_valid;
    logic              r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // An entry without its valid bit reads as an empty bin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else begin
            r_rvld <= r_valid[i_raddr];
            if (i_ctl.clear_all) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

>>> rtl/pahr_accum.sv
module pahr_accum #(
    parameter int ACC_W = 22
) (
    input  logic [ACC_W-1:0] i_a,
    input  logic [ACC_W-1:0] i_b,
    input  logic [ACC_W-1:0] i_limit,
    output logic [ACC_W-1:0] o_sum,
    output logic             o_reach
);

    // Shared add and compare: bin increment and running scan sum
    assign o_sum   = i_a + i_b;
    assign o_reach = (o_sum >= i_limit);

endmodule

>>> rtl/page_aging_histogram_reclaim_core.sv
// Page aging engine with a score histogram and a clock-hand victim picker.
// Items arrive on a valid/stall channel, and every item returns exactly one
// result on the output channel, one at a time. After reset the core runs a
// reset pass over all PAGE_COUNT pages of the table (65536 by default), one
// page per cycle, holding o_in_stall high throughout. An observe transfer
// of a resident page steps through a page-table read, a read-modify-write
// of score and swapped mark, a histogram increment and the hand-over of
// the result before the core is ready again. A swapped-out page skips the
// histogram step; a page index past the table or an unknown op goes
// straight to the hand-over. A close-scan transfer walks the histogram
// through its single read port and the shared adder, with a read state
// and an accumulate state per bin, until the running count reaches the
// target or the last bin is summed. A victim request tests one page per
// cycle through the page-table read port, starting at the clock hand, and
// stops at the first eligible page, or after one full turn when no page
// qualifies. A finished result sits in the output register while the next
// item may already be accepted; that item's result waits until the register
// is free.
module page_aging_histogram_reclaim_core import pahr_pkg::*; #(
    parameter int PAGE_COUNT     = PAHR_PAGE_COUNT,
    parameter int NUM_SCORE_BINS = PAHR_NUM_BINS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [OP_W-1:0]        i_op,
    input  logic [PAGE_IDX_W-1:0]  i_page_index,
    input  logic                   i_present,
    input  logic                   i_page_idle,
    input  logic                   i_in_huge_page,
    input  logic                   i_first_scan,
    input  logic [TARGET_W-1:0]    i_reclaim_target,
    input  logic                   i_take_any,

    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SCORE_OUT_W-1:0] o_new_score,
    output logic [SCORE_OUT_W-1:0] o_threshold_now,
    output logic [PAGE_IDX_W-1:0]  o_victim_index,
    output logic                   o_victim_found
);

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int SCORE_W = $clog2(NUM_SCORE_BINS);
    localparam int WORD_W  = SCORE_W + 1;
    // Running sum of all bins never exceeds NUM_SCORE_BINS * BIN_MAX
    localparam int ACC_W   = BIN_W + SCORE_W;
    localparam int CMP_W   = ((PAGE_W > PAGE_IDX_W) ? PAGE_W : PAGE_IDX_W) + 1;

    localparam logic [PAGE_W-1:0]  LAST_PAGE   = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [SCORE_W-1:0] LAST_BIN    = SCORE_W'(NUM_SCORE_BINS - 1);
    localparam logic [SCORE_W-1:0] BONUS_LIMIT = SCORE_W'(NUM_SCORE_BINS - 2);
    localparam logic [SCORE_W-1:0] RESET_SCORE = SCORE_W'(NUM_SCORE_BINS / 2);
    localparam logic [ACC_W-1:0]   BIN_LIMIT   = ACC_W'(BIN_MAX + 1);

    t_state r_state, n_state;

    // Latched item
    logic [PAGE_IDX_W-1:0] r_page, n_page;
    logic                  r_present, n_present;
    logic                  r_idle, n_idle;
    logic                  r_huge, n_huge;
    logic                  r_first, n_first;
    logic [TARGET_W-1:0]   r_target, n_target;
    logic                  r_any, n_any;

    // Sequencer and datapath state
    logic [PAGE_W-1:0]  r_ptr, n_ptr;
    logic [PAGE_W-1:0]  r_cnt, n_cnt;
    logic [PAGE_W-1:0]  r_chk_ptr, n_chk_ptr;
    logic               r_chk_vld, n_chk_vld;
    logic [PAGE_W-1:0]  r_hand, n_hand;
    logic [SCORE_W-1:0] r_thr, n_thr;
    logic [SCORE_W-1:0] r_bin, n_bin;
    logic [ACC_W-1:0]   r_sum, n_sum;
    logic [SCORE_W-1:0] r_new_s, n_new_s;

    // Result of the item in progress
    logic [SCORE_W-1:0] r_res_ns, n_res_ns;
    logic [PAGE_W-1:0]  r_res_vi, n_res_vi;
    logic               r_res_vf, n_res_vf;

    // Output register
    logic                   r_out_valid, n_out_valid;
    logic [SCORE_OUT_W-1:0] r_out_ns, n_out_ns;
    logic [SCORE_OUT_W-1:0] r_out_thr, n_out_thr;
    logic [PAGE_IDX_W-1:0]  r_out_vi, n_out_vi;
    logic                   r_out_vf, n_out_vf;

    // Memory ports
    logic               pm_we;
    logic [PAGE_W-1:0]  pm_waddr;
    logic [WORD_W-1:0]  pm_wdata;
    logic [PAGE_W-1:0]  pm_raddr;
    logic [WORD_W-1:0]  pm_rdata;
    t_hist_ctl          hm_ctl;
    logic [SCORE_W-1:0] hm_waddr;
    logic [BIN_W-1:0]   hm_wdata;
    logic [SCORE_W-1:0] hm_raddr;
    logic [BIN_W-1:0]   hm_rdata;

    // Shared adder
    logic [ACC_W-1:0] acc_a, acc_b, acc_limit, acc_sum;
    logic             acc_reach;

    logic               in_accept;
    logic               in_range;
    logic               out_free;
    logic [PAGE_W-1:0]  page_addr;
    logic [PAGE_W-1:0]  ptr_next;
    logic [PAGE_W-1:0]  chk_next;
    logic [SCORE_W-1:0] rd_score;
    logic               rd_swapped;
    logic [SCORE_W-1:0] s_bonus;
    logic [SCORE_W-1:0] s_upd;
    logic               eligible;
    logic               scanning;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_range   = (CMP_W'(i_page_index) < CMP_W'(PAGE_COUNT));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign page_addr  = PAGE_W'(r_page);
    assign ptr_next   = (r_ptr == LAST_PAGE) ? '0 : r_ptr + 1'b1;
    assign chk_next   = (r_chk_ptr == LAST_PAGE) ? '0 : r_chk_ptr + 1'b1;

    // Score update: huge-page bonus first, then age down if idle, up if used
    assign rd_score   = pm_rdata[SCORE_W-1:0];
    assign rd_swapped = pm_rdata[SCORE_W];
    assign s_bonus    = (r_first && r_huge && (rd_score < BONUS_LIMIT)) ?
                        rd_score + 1'b1 : rd_score;
    always_comb begin
        if (r_idle) begin
            s_upd = (s_bonus != '0) ? s_bonus - 1'b1 : s_bonus;
        end else begin
            s_upd = (s_bonus < LAST_BIN) ? s_bonus + 1'b1 : s_bonus;
        end
    end

    assign eligible = !rd_swapped && (r_any || (rd_score <= r_thr));

    // Adder serves the running scan sum or the bin increment
    assign scanning  = (r_state == S_SCAN_ACC);
    assign acc_a     = scanning ? r_sum : ACC_W'(hm_rdata);
    assign acc_b     = scanning ? ACC_W'(hm_rdata) : ACC_W'(1);
    assign acc_limit = scanning ? ACC_W'(r_target) : BIN_LIMIT;

    pahr_accum #(
        .ACC_W   (ACC_W)
    ) u_accum (
        .i_a     (acc_a),
        .i_b     (acc_b),
        .i_limit (acc_limit),
        .o_sum   (acc_sum),
        .o_reach (acc_reach)
    );

    pahr_page_mem #(
        .PAGE_COUNT (PAGE_COUNT),
        .ADDR_W     (PAGE_W),
        .DATA_W     (WORD_W)
    ) u_page_mem (
        .i_clk      (i_clk),
        .i_we       (pm_we),
        .i_waddr    (pm_waddr),
        .i_wdata    (pm_wdata),
        .i_raddr    (pm_raddr),
        .o_rdata    (pm_rdata)
    );

    pahr_hist_mem #(
        .DEPTH   (NUM_SCORE_BINS),
        .ADDR_W  (SCORE_W),
        .DATA_W  (BIN_W)
    ) u_hist_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hm_ctl),
        .i_waddr (hm_waddr),
        .i_wdata (hm_wdata),
        .i_raddr (hm_raddr),
        .o_rdata (hm_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_ptr == LAST_PAGE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_op)
                        OP_OBSERVE: n_state = in_range ? S_OBS_RD : S_DONE;
                        OP_CLOSE:   n_state = S_SCAN_RD;
                        OP_VICTIM:  n_state = S_VIC;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_OBS_RD:   n_state = S_OBS_UPD;
            S_OBS_UPD:  n_state = r_present ? S_OBS_HIST : S_DONE;
            S_OBS_HIST: n_state = S_DONE;
            S_SCAN_RD:  n_state = S_SCAN_ACC;
            S_SCAN_ACC: begin
                n_state = (acc_reach || (r_bin == LAST_BIN)) ? S_DONE : S_SCAN_RD;
            end
            S_VIC: begin
                if (r_chk_vld && (eligible || (r_cnt == LAST_PAGE))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_page    = r_page;
        n_present = r_present;
        n_idle    = r_idle;
        n_huge    = r_huge;
        n_first   = r_first;
        n_target  = r_target;
        n_any     = r_any;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_chk_ptr = r_chk_ptr;
        n_chk_vld = r_chk_vld;
        n_hand    = r_hand;
        n_thr     = r_thr;
        n_bin     = r_bin;
        n_sum     = r_sum;
        n_new_s   = r_new_s;
        n_res_ns  = r_res_ns;
        n_res_vi  = r_res_vi;
        n_res_vf  = r_res_vf;
        n_out_ns  = r_out_ns;
        n_out_thr = r_out_thr;
        n_out_vi  = r_out_vi;
        n_out_vf  = r_out_vf;

        // Drop the output once the downstream side takes it
        n_out_valid = r_out_valid && i_out_stall;

        pm_we            = 1'b0;
        pm_waddr         = page_addr;
        pm_wdata         = {1'b0, s_upd};
        pm_raddr         = page_addr;
        hm_ctl.wr_en     = 1'b0;
        hm_ctl.clear_all = 1'b0;
        hm_waddr         = r_new_s;
        hm_wdata         = acc_reach ? hm_rdata : acc_sum[BIN_W-1:0];
        hm_raddr         = r_bin;

        unique case (r_state)
            S_INIT: begin
                // Sweep the page table to its reset contents
                pm_we    = 1'b1;
                pm_waddr = r_ptr;
                pm_wdata = {1'b0, RESET_SCORE};
                n_ptr    = ptr_next;
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_page    = i_page_index;
                    n_present = i_present;
                    n_idle    = i_page_idle;
                    n_huge    = i_in_huge_page;
                    n_first   = i_first_scan;
                    n_target  = i_reclaim_target;
                    n_any     = i_take_any;
                    n_res_ns  = '0;
                    n_res_vi  = '0;
                    n_res_vf  = 1'b0;
                    n_bin     = '0;
                    n_sum     = '0;
                    n_ptr     = r_hand;
                    n_cnt     = '0;
                    n_chk_vld = 1'b0;
                end
            end
            S_OBS_RD: begin
                pm_raddr = page_addr;
            end
            S_OBS_UPD: begin
                pm_we = 1'b1;
                if (r_present) begin
                    pm_wdata = {1'b0, s_upd};
                    n_res_ns = s_upd;
                    n_new_s  = s_upd;
                    hm_raddr = s_upd;
                end else begin
                    // Mark swapped, keep the score
                    pm_wdata = {1'b1, rd_score};
                    n_res_ns = rd_score;
                end
            end
            S_OBS_HIST: begin
                // Saturating bin increment
                hm_ctl.wr_en = 1'b1;
                hm_waddr     = r_new_s;
                hm_wdata     = acc_reach ? hm_rdata : acc_sum[BIN_W-1:0];
            end
            S_SCAN_RD: begin
                hm_raddr = r_bin;
            end
            S_SCAN_ACC: begin
                n_sum = acc_sum;
                if (acc_reach) begin
                    n_thr            = r_bin;
                    hm_ctl.clear_all = 1'b1;
                end else if (r_bin == LAST_BIN) begin
                    n_thr            = LAST_BIN;
                    hm_ctl.clear_all = 1'b1;
                end else begin
                    n_bin = r_bin + 1'b1;
                end
            end
            S_VIC: begin
                // Issue one read per cycle, test the page read last cycle
                pm_raddr  = r_ptr;
                n_ptr     = ptr_next;
                n_chk_ptr = r_ptr;
                n_chk_vld = 1'b1;
                if (r_chk_vld) begin
                    if (eligible) begin
                        n_res_vi = r_chk_ptr;
                        n_res_vf = 1'b1;
                        n_hand   = chk_next;
                    end else if (r_cnt == LAST_PAGE) begin
                        // Full turn without a hit: hand is back at its start
                        n_hand = chk_next;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ns    = SCORE_OUT_W'(r_res_ns);
                    n_out_thr   = SCORE_OUT_W'(r_thr);
                    n_out_vi    = PAGE_IDX_W'(r_res_vi);
                    n_out_vf    = r_res_vf;
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_chk_vld   <= 1'b0;
            r_hand      <= '0;
            r_thr       <= LAST_BIN;
            r_bin       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_chk_vld   <= n_chk_vld;
            r_hand      <= n_hand;
            r_thr       <= n_thr;
            r_bin       <= n_bin;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_page    <= n_page;
        r_present <= n_present;
        r_idle    <= n_idle;
        r_huge    <= n_huge;
        r_first   <= n_first;
        r_target  <= n_target;
        r_any     <= n_any;
        r_chk_ptr <= n_chk_ptr;
        r_sum     <= n_sum;
        r_new_s   <= n_new_s;
        r_res_ns  <= n_res_ns;
        r_res_vi  <= n_res_vi;
        r_res_vf  <= n_res_vf;
        r_out_ns  <= n_out_ns;
        r_out_thr <= n_out_thr;
        r_out_vi  <= n_out_vi;
        r_out_vf  <= n_out_vf;
    end

    assign o_out_valid     = r_out_valid;
    assign o_new_score     = r_out_ns;
    assign o_threshold_now = r_out_thr;
    assign o_victim_index  = r_out_vi;
    assign o_victim_found  = r_out_vf;

endmodule

>>> rtl/pahr_checker.sv
module pahr_checker import pahr_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [SCORE_OUT_W-1:0] o_new_score,
    input logic [SCORE_OUT_W-1:0] o_threshold_now,
    input logic [PAGE_IDX_W-1:0]  o_victim_index,
    input logic                   o_victim_found
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_new_score) && $stable(o_threshold_now) &&
            $stable(o_victim_index) && $stable(o_victim_found))
        else $error("stalled result changed");

    // One item at a time: stall right after every accepted transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    a_no_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_victim_found |-> o_victim_index == '0)
        else $error("victim index without a victim");

    a_victim_no_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_victim_found |-> o_new_score == '0)
        else $error("score reported on a victim result");

endmodule

bind page_aging_histogram_reclaim_core pahr_checker u_pahr_checker (.*);
